[rtl/ultrasonic_echo_ranger_assert.svh]
// Assertion macros for the echo ranger.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UER_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define UER_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/uer_pkg.sv]
`default_nettype none

package uer_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_RISE = 2'd2,
        PH_FALL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_RANGE   = 2'd2,
        ST_BUSY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_TRIGGER_TICKS = 2'd0,
        CFG_TIMEOUT_TICKS = 2'd1,
        CFG_MIN_DIST      = 2'd2,
        CFG_MAX_DIST      = 2'd3
    } cfg_index_t;

    localparam int unsigned TRIG_W    = 8;
    localparam int unsigned TMO_W     = 24;
    localparam int unsigned DIST_W    = 9;
    localparam int unsigned CFG_W     = 24;
    localparam int unsigned THRESH_W  = 16;
    localparam int unsigned QUOT_IN_W = 15;
    localparam int unsigned PROD_W    = 30;

    localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 8'd15;
    localparam logic [TMO_W-1:0]  TIMEOUT_TICKS_RST = 24'd2000000;
    localparam logic [DIST_W-1:0] MIN_DIST_RST      = 9'd2;
    localparam logic [DIST_W-1:0] MAX_DIST_RST      = 9'd400;

    // floor(w / 58) == (w * 18079) >> 20 for every w below 174762
    localparam logic [QUOT_IN_W-1:0] CM_RECIP = 15'd18079;
    localparam int unsigned          CM_SHIFT = 20;

    // x * 58 as x*64 - x*4 - x*2
    function automatic logic [THRESH_W-1:0] times_cm(input logic [DIST_W:0] x);
        logic [THRESH_W-1:0] xe;
        begin
            xe = THRESH_W'(x);
            times_cm = (xe << 6) - (xe << 2) - (xe << 1);
        end
    endfunction

endpackage

`default_nettype wire

[rtl/ultrasonic_echo_ranger.sv]
// Channel   Dir  Ports                       Contents (lowest bit first)
// s_        in   s_tvalid/s_tready/s_tuser  tuser: cmd; tdata: echo_level
// m_        out  m_tvalid/m_tready/m_tdata  tdata: trigger_level, done_res,
//                                            distance_cm[8:0], status[1:0]
// cfg_      in   cfg_we/cfg_addr/cfg_wdata  register write, no read-back
//
// One item per cycle unless the result stalls, via the item and result registers.
// The item register feeds the phase/counter update and the width-to-cm
// multiply, which land in the result register in the same cycle.
// Synchronous active-low reset: phase idle, counters zero, registers at defaults.
// A stalled result holds the item register; the input stalls once both are full.
`default_nettype none

module ultrasonic_echo_ranger #(
    parameter int unsigned TIMER_BITS = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] echo_level
    input  wire logic        s_tuser,   // [0] cmd

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] trigger_level, [1] done_res,
                                        // [10:2] distance_cm, [12:11] status

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [uer_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int unsigned CMP_W = (TIMER_BITS > uer_pkg::TMO_W) ?
                                    TIMER_BITS : uer_pkg::TMO_W;
    localparam int unsigned WID_W = (TIMER_BITS > uer_pkg::THRESH_W) ?
                                    TIMER_BITS : uer_pkg::THRESH_W;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

    logic [uer_pkg::TRIG_W-1:0] trigger_ticks_reg;
    logic [uer_pkg::TMO_W-1:0]  timeout_ticks_reg;
    logic [uer_pkg::DIST_W-1:0] min_dist_reg;
    logic [uer_pkg::DIST_W-1:0] max_dist_reg;

    logic in_valid_reg;
    logic in_cmd_reg;
    logic in_echo_reg;

    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    uer_pkg::phase_t         phase_reg, phase_next;
    logic [TIMER_BITS-1:0]   wait_count_reg, wait_count_next;
    logic [TIMER_BITS-1:0]   echo_width_reg, echo_width_next;

    logic advance;
    logic [TIMER_BITS-1:0] wait_inc;
    logic [TIMER_BITS-1:0] width_inc;
    logic timed_out;
    logic trig_done;
    logic [uer_pkg::THRESH_W-1:0] min_w;
    logic [uer_pkg::THRESH_W-1:0] max_lim;
    logic in_range;
    logic [uer_pkg::PROD_W-1:0] prod;

    logic                       res_trigger;
    logic                       res_done;
    logic [uer_pkg::DIST_W-1:0] res_dist;
    uer_pkg::status_t           res_status;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_ticks_reg <= uer_pkg::TRIGGER_TICKS_RST;
            timeout_ticks_reg <= uer_pkg::TIMEOUT_TICKS_RST;
            min_dist_reg      <= uer_pkg::MIN_DIST_RST;
            max_dist_reg      <= uer_pkg::MAX_DIST_RST;
        end else if (cfg_we) begin
            unique case (uer_pkg::cfg_index_t'(cfg_addr))
                uer_pkg::CFG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_wdata[7:0];
                uer_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata[23:0];
                uer_pkg::CFG_MIN_DIST:      min_dist_reg      <= cfg_wdata[8:0];
                uer_pkg::CFG_MAX_DIST:      max_dist_reg      <= cfg_wdata[8:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_echo_reg <= s_tdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= uer_pkg::PH_IDLE;
            wait_count_reg <= '0;
            echo_width_reg <= '0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            wait_count_reg <= wait_count_next;
            echo_width_reg <= echo_width_next;
        end
    end

    assign wait_inc  = (wait_count_reg == CNT_MAX) ? CNT_MAX
                                                   : wait_count_reg + TIMER_BITS'(1);
    assign width_inc = (echo_width_reg == CNT_MAX) ? CNT_MAX
                                                   : echo_width_reg + TIMER_BITS'(1);
    assign timed_out = (CMP_W'(wait_inc) > CMP_W'(timeout_ticks_reg)) ||
                       (wait_inc == CNT_MAX);
    assign trig_done = CMP_W'(wait_inc) >= CMP_W'(trigger_ticks_reg);

    assign min_w    = uer_pkg::times_cm({1'b0, min_dist_reg});
    assign max_lim  = uer_pkg::times_cm({1'b0, max_dist_reg} + 10'd1);
    assign in_range = (width_inc != '0) &&
                      (WID_W'(width_inc) >= WID_W'(min_w)) &&
                      (WID_W'(width_inc) <  WID_W'(max_lim));
    assign prod     = uer_pkg::PROD_W'(width_inc[uer_pkg::QUOT_IN_W-1:0]) *
                      uer_pkg::PROD_W'(uer_pkg::CM_RECIP);

    always_comb begin
        phase_next      = phase_reg;
        wait_count_next = wait_count_reg;
        echo_width_next = echo_width_reg;
        res_done        = 1'b0;
        res_status      = uer_pkg::ST_BUSY;
        res_dist        = '0;
        if (in_cmd_reg) begin
            phase_next      = uer_pkg::PH_TRIG;
            wait_count_next = '0;
        end else begin
            unique case (phase_reg)
                uer_pkg::PH_TRIG: begin
                    wait_count_next = wait_inc;
                    if (trig_done) begin
                        phase_next      = uer_pkg::PH_RISE;
                        wait_count_next = '0;
                    end
                end
                uer_pkg::PH_RISE: begin
                    if (in_echo_reg) begin
                        phase_next      = uer_pkg::PH_FALL;
                        wait_count_next = '0;
                        echo_width_next = '0;
                    end else begin
                        wait_count_next = wait_inc;
                        if (timed_out) begin
                            phase_next = uer_pkg::PH_IDLE;
                            res_done   = 1'b1;
                            res_status = uer_pkg::ST_TIMEOUT;
                        end
                    end
                end
                uer_pkg::PH_FALL: begin
                    echo_width_next = width_inc;
                    if (!in_echo_reg) begin
                        phase_next = uer_pkg::PH_IDLE;
                        res_done   = 1'b1;
                        if (in_range) begin
                            res_status = uer_pkg::ST_OK;
                            res_dist   = prod[uer_pkg::CM_SHIFT +: uer_pkg::DIST_W];
                        end else begin
                            res_status = uer_pkg::ST_RANGE;
                        end
                    end else begin
                        wait_count_next = wait_inc;
                        if (timed_out) begin
                            phase_next = uer_pkg::PH_IDLE;
                            res_done   = 1'b1;
                            res_status = uer_pkg::ST_TIMEOUT;
                        end
                    end
                end
                default: ;
            endcase
        end
        res_trigger = (phase_next == uer_pkg::PH_TRIG);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {3'b000, res_status, res_dist, res_done, res_trigger};
        end
    end

`include "ultrasonic_echo_ranger_assert.svh"

    `UER_ASSERT_IMPL(a_idle_result, aclk, aresetn,
        m_tvalid && !m_tdata[1],
        m_tdata[12:11] == uer_pkg::ST_BUSY && m_tdata[10:2] == '0,
        "result without a finished measurement carries a distance or status")

    `UER_ASSERT_IMPL(a_done_no_trigger, aclk, aresetn,
        m_tvalid && m_tdata[1],
        !m_tdata[0] && m_tdata[12:11] != uer_pkg::ST_BUSY,
        "finished measurement with trigger high or busy status")

    `UER_ASSERT_NEXT(a_start_to_trigger, aclk, aresetn,
        advance && in_cmd_reg,
        phase_reg == uer_pkg::PH_TRIG && wait_count_reg == '0,
        "start item did not enter the trigger phase")

endmodule

`default_nettype wire
